### hw/rtl/cnlc_pkg.sv
// Shared constants and types for the card number classifier.
// No dependencies; the top level uses it by scoped names.
`default_nettype none
package cnlc_pkg;

    localparam int CARD_W     = 63;           // binary card number width
    localparam int BCD_DIGITS = 19;           // decimal digits of the widest card number
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int BIT_IDX_W  = $clog2(CARD_W);
    localparam int COUNT_W    = 5;
    localparam int BRAND_W    = 2;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [BRAND_W-1:0] brand_t;

    // Brand codes
    localparam brand_t BRAND_INVALID = 2'd0;  // failed check or no rule matched
    localparam brand_t BRAND_A15     = 2'd1;  // 15 digits, leading 34 or 37
    localparam brand_t BRAND_M16     = 2'd2;  // 16 digits, leading 51 to 55
    localparam brand_t BRAND_V1316   = 2'd3;  // 13 or 16 digits, leading 4

endpackage
`default_nettype wire

### hw/rtl/card_number_luhn_classifier.sv
// Card number classifier: binary to decimal conversion, Luhn mod-10 check, brand rules.
// Depends on cnlc_pkg (constants, digit and brand types).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_ready  | card_number[62:0]
//  out     | output    | out_valid / out_ready| brand[1:0], checksum_ok, digit_count[4:0]
//
// out_valid rises once an accepted item has been through the 63 shift-and-add-3 steps of the
// double-dabble unit, then through the Luhn accumulator at one digit a cycle, then through
// the classify step. in_ready is high only while idle, so a new item is accepted only
// after the previous one has left the classify step.
// The result sits in an output register, so the next item is accepted while it waits.
// A stalled output holds the finished item in the classify step until the register frees.
// rst_n clears all control state asynchronously; payload registers are not reset.
`default_nettype none
module card_number_luhn_classifier #(
    parameter int MAX_DIGITS = 19
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cnlc_pkg::CARD_W-1:0]   card_number,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cnlc_pkg::BRAND_W-1:0]       brand,
    output logic                               checksum_ok,
    output logic [cnlc_pkg::COUNT_W-1:0]       digit_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [cnlc_pkg::BIT_IDX_W-1:0] LAST_BIT =
        cnlc_pkg::BIT_IDX_W'(cnlc_pkg::CARD_W - 1);
    localparam logic [cnlc_pkg::COUNT_W-1:0] LAST_DIGIT =
        cnlc_pkg::COUNT_W'(MAX_DIGITS - 1);
    localparam logic [cnlc_pkg::COUNT_W-1:0] MAX_COUNT =
        cnlc_pkg::COUNT_W'(MAX_DIGITS);

    // control state
    logic [1:0]                         state_reg, state_next;
    logic                               out_valid_reg, out_valid_next;
    // working registers
    logic [cnlc_pkg::BIT_IDX_W-1:0]     bit_idx_reg, bit_idx_next;
    logic [cnlc_pkg::COUNT_W-1:0]       digit_idx_reg, digit_idx_next;
    logic [cnlc_pkg::CARD_W-1:0]        bin_reg, bin_next;
    logic [cnlc_pkg::BCD_W-1:0]         bcd_reg, bcd_next;
    cnlc_pkg::digit_t                   acc_reg, acc_next;     // digit sum mod 10
    cnlc_pkg::digit_t                   prev_reg, prev_next;   // digit one place lower
    cnlc_pkg::digit_t                   first_reg, first_next;
    cnlc_pkg::digit_t                   second_reg, second_next;
    logic [cnlc_pkg::COUNT_W-1:0]       count_reg, count_next;
    // output register
    cnlc_pkg::brand_t                   brand_reg, brand_next;
    logic                               ok_reg, ok_next;
    logic [cnlc_pkg::COUNT_W-1:0]       dcount_reg, dcount_next;

    // shared datapath signals
    logic [cnlc_pkg::BCD_W-1:0]         bcd_adj;
    cnlc_pkg::digit_t                   cur_digit;
    logic [4:0]                         dbl;
    cnlc_pkg::digit_t                   weighed;
    logic [4:0]                         acc_sum;
    logic                               overflow;
    logic                               chk_ok;
    logic                               slot_free;
    cnlc_pkg::brand_t                   brand_cls;
    logic [cnlc_pkg::COUNT_W-1:0]       count_fin;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign brand       = brand_reg;
    assign checksum_ok = ok_reg;
    assign digit_count = dcount_reg;

    // Double-dabble correction: add 3 to every BCD digit of 5 or more before the shift.
    always_comb
    begin
        for (int k = 0; k < cnlc_pkg::BCD_DIGITS; k++)
        begin
            if (bcd_reg[k*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] >= 4'd5)
                bcd_adj[k*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] =
                    bcd_reg[k*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] + 4'd3;
            else
                bcd_adj[k*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] =
                    bcd_reg[k*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W];
        end
    end

    // Luhn weighting of the lowest remaining digit: double at odd places, fold above 9.
    always_comb
    begin
        cur_digit = bcd_reg[cnlc_pkg::DIGIT_W-1:0];
        dbl       = {cur_digit, 1'b0};
        if (digit_idx_reg[0])
            weighed = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
        else
            weighed = cur_digit;
        acc_sum = {1'b0, acc_reg} + {1'b0, weighed};
    end

    // Classification from the scan results; the remaining BCD digits flag overflow.
    always_comb
    begin
        overflow  = |bcd_reg;
        chk_ok    = (acc_reg == 4'd0);
        count_fin = overflow ? MAX_COUNT : count_reg;
        brand_cls = cnlc_pkg::BRAND_INVALID;
        if (chk_ok && !overflow && count_reg != '0)
        begin
            if (count_reg == 5'd15 && first_reg == 4'd3 &&
                (second_reg inside {4'd4, 4'd7}))
                brand_cls = cnlc_pkg::BRAND_A15;
            else if (count_reg == 5'd16 && first_reg == 4'd5 &&
                     (second_reg inside {[4'd1:4'd5]}))
                brand_cls = cnlc_pkg::BRAND_M16;
            else if ((count_reg inside {5'd13, 5'd16}) && first_reg == 4'd4)
                brand_cls = cnlc_pkg::BRAND_V1316;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        bit_idx_next   = bit_idx_reg;
        digit_idx_next = digit_idx_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        acc_next       = acc_reg;
        prev_next      = prev_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        count_next     = count_reg;
        brand_next     = brand_reg;
        ok_next        = ok_reg;
        dcount_next    = dcount_reg;

        // drop the result once it is taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bin_next     = card_number;
                    bcd_next     = '0;
                    bit_idx_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // shift the binary word into the corrected BCD register, msb first
                bcd_next     = {bcd_adj[cnlc_pkg::BCD_W-2:0], bin_reg[cnlc_pkg::CARD_W-1]};
                bin_next     = {bin_reg[cnlc_pkg::CARD_W-2:0], 1'b0};
                bit_idx_next = bit_idx_reg + 1'b1;
                if (bit_idx_reg == LAST_BIT)
                begin
                    digit_idx_next = '0;
                    acc_next       = '0;
                    prev_next      = '0;
                    first_next     = '0;
                    second_next    = '0;
                    count_next     = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // advance one digit from the right
                acc_next  = (acc_sum >= 5'd10) ? 4'(acc_sum - 5'd10) : acc_sum[3:0];
                prev_next = cur_digit;
                if (cur_digit != 4'd0)
                begin
                    count_next  = digit_idx_reg + 1'b1;
                    first_next  = cur_digit;
                    second_next = prev_reg;
                end
                bcd_next       = {{cnlc_pkg::DIGIT_W{1'b0}},
                                  bcd_reg[cnlc_pkg::BCD_W-1:cnlc_pkg::DIGIT_W]};
                digit_idx_next = digit_idx_reg + 1'b1;
                if (digit_idx_reg == LAST_DIGIT)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    brand_next     = brand_cls;
                    ok_next        = chk_ok;
                    dcount_next    = count_fin;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_idx_reg   <= bit_idx_next;
        digit_idx_reg <= digit_idx_next;
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        acc_reg       <= acc_next;
        prev_reg      <= prev_next;
        first_reg     <= first_next;
        second_reg    <= second_next;
        count_reg     <= count_next;
        brand_reg     <= brand_next;
        ok_reg        <= ok_next;
        dcount_reg    <= dcount_next;
    end

endmodule
`default_nettype wire
